// ===== hdl/epwr_pkg.sv =====
package epwr_pkg;

    localparam logic [1:0] CMD_WRAP = 2'd0;
    localparam logic [1:0] CMD_RISE = 2'd1;
    localparam logic [1:0] CMD_FALL = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_NOT_DONE = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    localparam logic [1:0] REG_TIMER_PERIOD  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR  = 2'd2;

    localparam logic [15:0] TIMER_PERIOD_RST  = 16'd1000;
    localparam logic [5:0]  TIMEOUT_LIMIT_RST = 6'd63;
    localparam logic [9:0]  SCALE_FACTOR_RST  = 10'd174;

    localparam int SCALE_SHIFT = 10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] capture_count;
    } in_t;

    typedef struct packed {
        logic [21:0] distance;
        logic [1:0]  status;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic exec;     // transaction accepted, apply its command
        logic ticks_en; // form overflow * period + count
        logic prod_en;  // form ticks * scale
        logic load_en;  // load the result register
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/epwr_ctrl.sv =====
module epwr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         cmd,
    input  epwr_pkg::stat_t    stat,
    output epwr_pkg::ctrl_t    ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        ctrl          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctrl.exec = 1'b1;
                    if (cmd == epwr_pkg::CMD_READ) begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                ctrl.ticks_en = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2: begin
                ctrl.prod_en = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    ctrl.load_en = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a read walks the multiply chain in order
    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ticks_en |=> ctrl.prod_en)
        else $error("product stage did not follow ticks stage");

    a_read_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.exec && cmd == epwr_pkg::CMD_READ) |=> ctrl.ticks_en)
        else $error("read did not start the multiply chain");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_en |-> stat.out_free)
        else $error("result loaded over a waiting result");

endmodule

// ===== hdl/epwr_dp.sv =====
module epwr_dp #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  epwr_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output epwr_pkg::out_t     m_data,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  epwr_pkg::ctrl_t    ctrl,
    output epwr_pkg::stat_t    stat
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(FIFO_DEPTH);

    logic [15:0] period_reg;
    logic [5:0]  limit_reg;
    logic [9:0]  scale_reg;

    logic        armed_reg;
    logic        done_reg;
    logic [5:0]  ovf_reg;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] tail_reg;
    logic [FW-1:0] fill_reg;

    logic [21:0] mem [FIFO_DEPTH];
    logic [21:0] rd_reg;
    logic [1:0]  status_reg;
    logic [21:0] ticks_reg;
    logic [31:0] prod_reg;
    logic        m_valid_reg;
    epwr_pkg::out_t out_reg;

    logic is_wrap, is_rise, is_fall, is_read;
    logic push, pop;
    logic [PW-1:0] head_inc, tail_inc;

    assign is_wrap = ctrl.exec && (s_data.cmd == epwr_pkg::CMD_WRAP);
    assign is_rise = ctrl.exec && (s_data.cmd == epwr_pkg::CMD_RISE);
    assign is_fall = ctrl.exec && (s_data.cmd == epwr_pkg::CMD_FALL);
    assign is_read = ctrl.exec && (s_data.cmd == epwr_pkg::CMD_READ);
    assign push    = is_fall && armed_reg && !done_reg;
    assign pop     = is_read && done_reg && (fill_reg != '0);

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= epwr_pkg::TIMER_PERIOD_RST;
            limit_reg  <= epwr_pkg::TIMEOUT_LIMIT_RST;
            scale_reg  <= epwr_pkg::SCALE_FACTOR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                epwr_pkg::REG_TIMER_PERIOD:  period_reg <= cfg_data;
                epwr_pkg::REG_TIMEOUT_LIMIT: limit_reg  <= cfg_data[5:0];
                epwr_pkg::REG_SCALE_FACTOR:  scale_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
            ovf_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            if (is_wrap && armed_reg && !done_reg) begin
                if (ovf_reg >= limit_reg) begin
                    done_reg <= 1'b1;
                end else begin
                    ovf_reg <= ovf_reg + 1'b1;
                end
            end
            if (is_rise && !done_reg) begin
                armed_reg <= 1'b1;
                ovf_reg   <= '0;
            end
            if (push) begin
                done_reg <= 1'b1;
                tail_reg <= tail_inc;
                if (fill_reg == FULL_FILL) begin
                    head_reg <= head_inc;  // drop the oldest entry
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (is_read && done_reg) begin
                done_reg  <= 1'b0;
                armed_reg <= 1'b0;
            end
            if (pop) begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= {ovf_reg, s_data.capture_count};
        end
        if (is_read) begin
            rd_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (is_read) begin
            if (!done_reg) begin
                status_reg <= epwr_pkg::ST_NOT_DONE;
            end else if (fill_reg == '0) begin
                status_reg <= epwr_pkg::ST_EMPTY;
            end else begin
                status_reg <= epwr_pkg::ST_VALID;
            end
        end
        if (ctrl.ticks_en) begin
            ticks_reg <= 22'(rd_reg[21:16]) * 22'(period_reg) + 22'(rd_reg[15:0]);
        end
        if (ctrl.prod_en) begin
            prod_reg <= 32'(ticks_reg) * 32'(scale_reg);
        end
        if (ctrl.load_en) begin
            out_reg.status   <= status_reg;
            out_reg.distance <= (status_reg == epwr_pkg::ST_VALID) ?
                                prod_reg[epwr_pkg::SCALE_SHIFT +: 22] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_FILL)
        else $error("queue fill above depth");

    a_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != epwr_pkg::ST_VALID) |-> (out_reg.distance == '0))
        else $error("nonzero distance with invalid status");

    a_pop_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("pop did not reduce fill");

endmodule

// ===== hdl/echo_pulse_width_ranger.sv =====
// Echo pulse width ranger.
// Input channel s_valid/s_ready/s_data carries event transactions: timer wrap,
// rising edge, falling edge (with the latched capture count) and read. Only a
// read produces a transaction on the result channel m_valid/m_ready/m_data,
// holding the distance and a status code.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high. Write registers only while the block is idle.
// Wrap and edge transactions are accepted back to back while no read is busy.
// A read passes through its steps before the next transaction is accepted: queue
// memory read, overflow * period + count multiply, scale multiply, result
// load. m_valid rises when the load step registers the result.
// Each of the two chained multipliers has a step of its own.
// If the receiver stalls, the result register holds its transaction; events
// keep being accepted, and a following read waits in its load step until the
// result register frees.
// Reset (aresetn low, synchronous) restores register defaults, clears armed,
// done, overflow count and the queue pointers, and drops any waiting result.
module echo_pulse_width_ranger #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  epwr_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output epwr_pkg::out_t     m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    epwr_pkg::ctrl_t ctrl;
    epwr_pkg::stat_t stat;

    // registers take every write immediately
    assign cfg_ready = 1'b1;

    epwr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (s_data.cmd),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    epwr_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int QDEPTH = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // index with no register behind it; the block must drop the write
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        epwr_pkg::in_t ev;
        int unsigned   gap;
    } queued_event_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid = 1'b0;
    logic           s_ready;
    epwr_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b1;
    epwr_pkg::out_t m_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [15:0]    cfg_data;

    echo_pulse_width_ranger #(
        .FIFO_DEPTH(QDEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: registers as last written, and the ranging state
    // ------------------------------------------------------------------
    logic [15:0] period_r = epwr_pkg::TIMER_PERIOD_RST;
    logic [5:0]  limit_r  = epwr_pkg::TIMEOUT_LIMIT_RST;
    logic [9:0]  scale_r  = epwr_pkg::SCALE_FACTOR_RST;

    logic        is_armed = 1'b0;
    logic        is_done  = 1'b0;
    logic [5:0]  ovf_run  = '0;
    logic [15:0] q_count [QDEPTH];
    logic [5:0]  q_ovf   [QDEPTH];
    int          q_head = 0;
    int          q_tail = 0;
    int          q_fill = 0;

    epwr_pkg::out_t expected_ranges [$];
    queued_event_t  event_backlog [$];

    // Sender staging: the item being presented or waiting out its gap
    queued_event_t staged;
    logic          staged_ok = 1'b0;
    logic          in_fire   = 1'b0;
    logic          out_fire  = 1'b0;

    // Shared knobs and counters
    logic        quiet = 1'b0;
    int unsigned rx_wait = 0;
    int unsigned idle_cycles = 0;
    int          err_count = 0;
    int          items_queued = 0;
    int          events_taken = 0;
    int          ranges_checked = 0;
    int          cfg_writes = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb_top: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Advance the predictor by one accepted event; queue the result of a read.
    task automatic predict_ranger(input epwr_pkg::in_t ev);
        epwr_pkg::out_t res;
        logic [63:0]    ticks;
        logic [63:0]    scaled;
        case (ev.cmd)
            epwr_pkg::CMD_WRAP: begin
                if (is_armed && !is_done) begin
                    // at the limit, abandon the echo and leave the count alone
                    if (ovf_run >= limit_r) is_done = 1'b1;
                    else ovf_run = ovf_run + 6'd1;
                end
            end
            epwr_pkg::CMD_RISE: begin
                // a rising edge restarts any measurement unless one is done
                if (!is_done) begin
                    is_armed = 1'b1;
                    ovf_run  = '0;
                end
            end
            epwr_pkg::CMD_FALL: begin
                if (!is_done && is_armed) begin
                    q_count[q_tail] = ev.capture_count;
                    q_ovf[q_tail]   = ovf_run;
                    q_tail = (q_tail + 1) % QDEPTH;
                    // full queue: drop the oldest entry
                    if (q_fill == QDEPTH) q_head = (q_head + 1) % QDEPTH;
                    else q_fill++;
                    is_done = 1'b1;
                end
            end
            epwr_pkg::CMD_READ: begin
                res.distance = '0;
                if (!is_done) begin
                    res.status = epwr_pkg::ST_NOT_DONE;
                end else begin
                    if (q_fill == 0) begin
                        res.status = epwr_pkg::ST_EMPTY;
                    end else begin
                        ticks  = 64'(q_ovf[q_head]) * 64'(period_r) + 64'(q_count[q_head]);
                        scaled = (ticks * 64'(scale_r)) >> epwr_pkg::SCALE_SHIFT;
                        res.distance = scaled[21:0];
                        res.status   = epwr_pkg::ST_VALID;
                        q_head = (q_head + 1) % QDEPTH;
                        q_fill--;
                    end
                    is_done  = 1'b0;
                    is_armed = 1'b0;
                end
                expected_ranges.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Event sender: owns s_valid/s_data, drives at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_fire)) begin
            // previous transaction is gone (or none was up): stage the next one
            if (!staged_ok && event_backlog.size() > 0) begin
                staged    = event_backlog.pop_front();
                staged_ok = 1'b1;
            end
            if (staged_ok && staged.gap == 0) begin
                s_valid   <= 1'b1;
                s_data    <= staged.ev;
                staged_ok = 1'b0;
            end else begin
                s_valid <= 1'b0;
                if (staged_ok) staged.gap--;
            end
        end
    end

    // Result receiver: after each result, draw a stall and hold m_ready low for it
    always @(negedge aclk) begin
        int unsigned w;
        if (out_fire) begin
            w = quiet ? 0 : $urandom_range(0, 11);
            if (w > 0) begin
                m_ready <= 1'b0;
                rx_wait <= w - 1;
            end else begin
                m_ready <= 1'b1;
                rx_wait <= 0;
            end
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: predict on accepted events, check results, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        epwr_pkg::out_t want;
        in_fire  <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_ranger(s_data);
            events_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch("result with nothing outstanding, status", m_data.status, -1);
            end else begin
                want = expected_ranges.pop_front();
                if (m_data.distance !== want.distance)
                    report_mismatch("distance", m_data.distance, want.distance);
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
            end
            ranges_checked++;
        end
        // count cycles in which no channel moves a transaction
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired after %0d idle cycles", idle_cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_cap();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one event; throttle so the idle knob tracks what goes out.
    task automatic send_event(input logic [1:0] cmd, input logic [15:0] cap);
        queued_event_t item;
        while (event_backlog.size() >= 4) @(posedge aclk);
        item.ev.cmd           = cmd;
        item.ev.capture_count = cap;
        item.gap              = quiet ? 0 : $urandom_range(0, 11);
        event_backlog.push_back(item);
        items_queued++;
    endtask

    // Hold the sender until every event is out and every result is back,
    // then let the block idle before returning.
    task automatic settle_block();
        while (event_backlog.size() != 0 || staged_ok || s_valid) @(posedge aclk);
        while (expected_ranges.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        settle_block();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            epwr_pkg::REG_TIMER_PERIOD:  period_r = val;
            epwr_pkg::REG_TIMEOUT_LIMIT: limit_r  = val[5:0];
            epwr_pkg::REG_SCALE_FACTOR:  scale_r  = val[9:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Write all three registers; fill unused upper bits with noise.
    task automatic apply_settings(input logic [15:0] period, input logic [5:0] limit,
                                  input logic [9:0] scale);
        write_reg(epwr_pkg::REG_TIMER_PERIOD, period);
        write_reg(epwr_pkg::REG_TIMEOUT_LIMIT, {10'($urandom), limit});
        write_reg(epwr_pkg::REG_SCALE_FACTOR, {6'($urandom), scale});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_reads();
        // nothing armed: reads report no measurement, stray events do nothing
        send_event(epwr_pkg::CMD_READ, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'hFFFF);
        send_event(epwr_pkg::CMD_WRAP, 16'hFFFF);
        send_event(epwr_pkg::CMD_READ, 16'hFFFF);
    endtask

    task automatic test_basic_capture();
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'hFFFF);
        send_event(epwr_pkg::CMD_READ, 16'h0000);
        // done was cleared by the read
        send_event(epwr_pkg::CMD_READ, 16'h0000);
    endtask

    task automatic test_edges_while_done();
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'h5A5A);
        // capture is closed until the read: these must all be dropped
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'hA5A5);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_READ, 16'h0000);
    endtask

    task automatic test_rearm();
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'h0001);
        send_event(epwr_pkg::CMD_READ, 16'h0000);
    endtask

    task automatic test_timeout();
        apply_settings(epwr_pkg::TIMER_PERIOD_RST, 6'd0, epwr_pkg::SCALE_FACTOR_RST);
        // zero limit: first wrap abandons the echo, read finds the queue empty
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_READ, 16'h0000);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_NONE, 16'($urandom));
        apply_settings(16'd0, 6'd63, 10'd1023);
        send_event(epwr_pkg::CMD_RISE, 16'h0000);
        send_event(epwr_pkg::CMD_WRAP, 16'h0000);
        send_event(epwr_pkg::CMD_FALL, 16'hFFFF);
        send_event(epwr_pkg::CMD_READ, 16'h0000);
    endtask

    task automatic test_random_sessions();
        logic [15:0] per_set [6];
        logic [5:0]  lim_set [6];
        logic [9:0]  scl_set [6];
        int          stop_at;
        int          mid;
        int          n_wraps;
        logic        paused;
        per_set = '{16'd1000, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd0};
        lim_set = '{6'd63, 6'd63, 6'd0, 6'd5, 6'd0, 6'd0};
        scl_set = '{10'd174, 10'd1023, 10'd0, 10'd512, 10'd0, 10'd0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph >= 4) begin
                per_set[ph] = 16'($urandom);
                lim_set[ph] = 6'($urandom_range(0, 12));
                scl_set[ph] = 10'($urandom);
            end
            quiet = 1'b0;
            apply_settings(per_set[ph], lim_set[ph], scl_set[ph]);
            stop_at = items_queued + 65;
            mid     = items_queued + 32;
            paused  = 1'b0;
            while (items_queued < stop_at) begin
                quiet = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) < 8) begin
                    // well-formed echo: arm, count wraps, capture, read back
                    send_event(epwr_pkg::CMD_RISE, rand_cap());
                    n_wraps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70)
                                                          : $urandom_range(0, 4);
                    for (int i = 0; i < n_wraps; i++) begin
                        send_event(epwr_pkg::CMD_WRAP, rand_cap());
                        if ($urandom_range(0, 19) == 0)
                            send_event(epwr_pkg::CMD_RISE, rand_cap());
                    end
                    if ($urandom_range(0, 4) != 0) send_event(epwr_pkg::CMD_FALL, rand_cap());
                    if ($urandom_range(0, 5) == 0)
                        send_event($urandom_range(0, 1) ? epwr_pkg::CMD_RISE
                                                        : epwr_pkg::CMD_FALL, rand_cap());
                    send_event(epwr_pkg::CMD_READ, rand_cap());
                    if ($urandom_range(0, 7) == 0) send_event(epwr_pkg::CMD_READ, rand_cap());
                end else begin
                    // noise
                    repeat ($urandom_range(1, 4)) send_event(2'($urandom), rand_cap());
                end
                if (!paused && items_queued >= mid) begin
                    settle_block();
                    paused = 1'b1;
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = epwr_pkg::REG_TIMER_PERIOD;
        cfg_data  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_reads();
        test_basic_capture();
        test_edges_while_done();
        test_rearm();
        test_timeout();
        test_register_extremes();
        test_random_sessions();

        // drain everything still in flight, then give the pipeline time
        settle_block();
        repeat (10) @(posedge aclk);

        $display("tb_top: %0d events accepted, %0d distance reads checked, %0d register writes",
                 events_taken, ranges_checked, cfg_writes);
        $display("tb_top: six register settings incl. extremes, %0d mismatches", err_count);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/epwr_pkg.sv
hdl/epwr_ctrl.sv
hdl/epwr_dp.sv
hdl/echo_pulse_width_ranger.sv
test/tb_top.sv
